@@ sv/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition a implies condition b in the next cycle
`define ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

@@ sv/imupf_pkg.sv @@
// shared types and constants of the imu packet framer
`timescale 1ns / 1ps
package imupf_pkg;

  localparam int PKT_LEN  = 11;
  localparam int FILL_W   = $clog2(PKT_LEN + 1);
  localparam int IDX_W    = $clog2(PKT_LEN);

  localparam logic [7:0]  HEADER_BYTE        = 8'h55;
  localparam logic [7:0]  ANGLE_TYPE         = 8'h53;
  localparam logic [15:0] QUARTER_TURN       = 16'd16384;
  localparam logic [15:0] THREE_QUARTER_TURN = 16'd49152;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 64;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // back end sequencer states
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_LOAD   = 3'd0;
  localparam logic [ST_W-1:0] ST_SUM    = 3'd1;
  localparam logic [ST_W-1:0] ST_DECIDE = 3'd2;
  localparam logic [ST_W-1:0] ST_SHIFT  = 3'd3;
  localparam logic [ST_W-1:0] ST_EMIT   = 3'd4;

  // one received byte, tagged with whether it is a header byte
  typedef struct packed {
    logic       hdr;
    logic [7:0] data;
  } q_item_t;

  // status of the back end, seen by the top level
  typedef struct packed {
    logic [ST_W-1:0]   state;
    logic [FILL_W-1:0] fill;
  } back_stat_t;

endpackage

@@ sv/imu_packet_framer_yaw_unwrap.sv @@
// top level of the imu packet framer with yaw unwrapping
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready   | in_tdata[7:0] rx_byte
//  out_    | out | out_tvalid/out_tready | out_tdata angle_count, yaw_raw, turn_count
//
// the sequencer loads each byte into the store; the byte that completes the
// 11-byte store starts a checksum pass over bytes 0 to 9, a decision step and a
// header search if needed (one byte dropped per cycle); angle packets then get emitted.
// reset (rst_n low, synchronous) empties the queue and store, hunting mode, zero turns.
// a stalled result holds the sequencer in its emit step; bytes queue while the queue has room.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module imu_packet_framer_yaw_unwrap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [imupf_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] rx_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] angle_count, [47:32] yaw_raw, [63:48] turn_count
  output logic [imupf_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import imupf_pkg::*;

  logic       fr_valid, fr_ready;
  q_item_t    fr_item;
  logic       q_valid, q_ready;
  q_item_t    q_item;
  back_stat_t stat;

  imupf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item       (fr_item)
  );

  imupf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  imupf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

  `ASSERT_AT(a_fill_range, stat.fill <= FILL_W'(PKT_LEN), "store fill count out of range")
  `ASSERT_AT(a_load_not_full, (stat.state != ST_LOAD) || (stat.fill < FILL_W'(PKT_LEN)),
             "sequencer loading into a full store")
  `ASSERT_AT(a_pull_only_loading, !q_ready || (stat.state == ST_LOAD),
             "queue drained outside the load step")
  `ASSERT_NEXT(a_emit_shows, (stat.state == ST_EMIT) && (!out_tvalid || out_tready),
               out_tvalid && (stat.state == ST_LOAD), "emit step did not present a result")

endmodule

@@ sv/imupf_front.sv @@
// input stage: takes serial bytes and tags header bytes
`timescale 1ns / 1ps
module imupf_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,
  output logic                     item_valid,
  input  logic                     item_ready,
  output imupf_pkg::q_item_t       item
);
  import imupf_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  q_item_t item_r;

  assign in_tready  = !vld_r || item_ready;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (item_ready) begin
      vld_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data <= in_tdata;
      item_r.hdr  <= (in_tdata == HEADER_BYTE);
    end
  end

endmodule

@@ sv/imupf_queue.sv @@
// small byte queue between the input stage and the packet sequencer
`timescale 1ns / 1ps
module imupf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  imupf_pkg::q_item_t  wr_item,
  output logic                rd_valid,
  input  logic                rd_ready,
  output imupf_pkg::q_item_t  rd_item
);
  import imupf_pkg::*;

  q_item_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != QCNT_W'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ sv/imupf_back.sv @@
// packet sequencer: fills the store, checks, hunts for the header, unwraps yaw
`timescale 1ns / 1ps
module imupf_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  imupf_pkg::q_item_t                   item,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [imupf_pkg::OUT_DATA_W-1:0]     out_tdata,
  output imupf_pkg::back_stat_t                stat
);
  import imupf_pkg::*;

  logic [ST_W-1:0]       state_r, state_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [7:0]            sum_r, sum_nxt;
  logic                  synced_r, synced_nxt;
  logic [15:0]           last_yaw_r, last_yaw_nxt;
  logic [15:0]           turns_r, turns_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [7:0]            store_r [PKT_LEN];
  logic                  hdr_r   [PKT_LEN];

  logic                  sum_ok;
  logic                  take_pkt;
  logic                  out_free;
  logic                  emit;
  logic [15:0]           yaw;
  logic [15:0]           turns_upd;

  assign item_ready = (state_r == ST_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign stat.state = state_r;
  assign stat.fill  = fill_r;

  assign sum_ok   = (sum_r == store_r[PKT_LEN-1]);
  // synced packets only need the checksum, hunting ones also need the header up front
  assign take_pkt = sum_ok && (synced_r || hdr_r[0]);
  assign out_free = !out_valid_r || out_tready;
  assign emit     = (state_r == ST_EMIT) && out_free;
  assign yaw      = {store_r[7], store_r[6]};

  always_comb begin
    turns_upd = turns_r;
    if (last_yaw_r < QUARTER_TURN && yaw > THREE_QUARTER_TURN) begin
      turns_upd = turns_r - 16'd1;
    end else if (last_yaw_r > THREE_QUARTER_TURN && yaw < QUARTER_TURN) begin
      turns_upd = turns_r + 16'd1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    synced_nxt    = synced_r;
    last_yaw_nxt  = last_yaw_r;
    turns_nxt     = turns_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_LOAD: begin
        if (item_valid) begin
          fill_nxt = fill_r + 1'b1;
          if (fill_r == FILL_W'(PKT_LEN - 1)) begin
            state_nxt = ST_SUM;
            cnt_nxt   = '0;
            sum_nxt   = '0;
          end
        end
      end
      ST_SUM: begin
        // one byte of the checksum per cycle, bytes 0 to 9
        sum_nxt = sum_r + store_r[cnt_r];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(PKT_LEN - 2)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        synced_nxt = take_pkt;
        if (take_pkt) begin
          fill_nxt  = '0;
          state_nxt = (store_r[1] == ANGLE_TYPE) ? ST_EMIT : ST_LOAD;
        end else if (hdr_r[0]) begin
          fill_nxt  = '0;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // drop one leading byte per cycle until a header leads or nothing is left
        fill_nxt = fill_r - 1'b1;
        if (fill_r == FILL_W'(1) || hdr_r[1]) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          last_yaw_nxt  = yaw;
          turns_nxt     = turns_upd;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        fill_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      synced_r    <= 1'b0;
      last_yaw_r  <= '0;
      turns_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      synced_r    <= synced_nxt;
      last_yaw_r  <= last_yaw_nxt;
      turns_r     <= turns_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && item_valid) begin
      store_r[fill_r[IDX_W-1:0]] <= item.data;
      hdr_r[fill_r[IDX_W-1:0]]   <= item.hdr;
    end else if (state_r == ST_SHIFT) begin
      for (int i = 0; i < PKT_LEN - 1; i++) begin
        store_r[i] <= store_r[i+1];
        hdr_r[i]   <= hdr_r[i+1];
      end
    end
  end

  // angle is turns above yaw, so turns * 65536 + yaw needs no arithmetic
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {turns_upd, yaw, turns_upd, yaw};
    end
  end

endmodule

@@ verif/tb_imu_packet_framer_yaw_unwrap.sv @@
// testbench for the imu packet framer: byte streams checked against a yaw-unwrap predictor
`timescale 1ns / 1ps
module tb_imu_packet_framer_yaw_unwrap;
  import imupf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_BYTES = 1130;
  localparam int MAX_REPORTS  = 10;
  localparam int N_DIRECTED   = 24;

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [15:0] turn_count;
    logic [15:0] yaw_raw;
    logic [31:0] angle_count;
  } yaw_result_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        known;
    yaw_result_t result;
  } dir_row_t;

  // two noise bytes, a yaw packet whose header is found by shifting (yaw 0xffff,
  // one turn down from reset), then a synced yaw packet at 0 (back up one turn)
  localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{HEADER_BYTE, 1'b0, '0},
    '{ANGLE_TYPE, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hA6, 1'b1, '{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}},
    '{HEADER_BYTE, 1'b0, '0},
    '{ANGLE_TYPE, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hA8, 1'b1, '{16'h0000, 16'h0000, 32'h0000_0000}}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;           // [31:0] angle_count, [47:32] yaw_raw, [63:48] turn_count

  imu_packet_framer_yaw_unwrap dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor state, at its reset values
  logic [7:0]  pkt_bytes [PKT_LEN];
  int          pkt_fill   = 0;
  bit          locked     = 1'b0;
  logic [15:0] prev_yaw   = 16'd0;
  logic [15:0] turn_total = 16'd0;

  yaw_result_t pending_angles [$];
  yaw_result_t seen_angle;
  yaw_result_t due_angle;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned gap_pct        = 0;
  int unsigned stall_pct      = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] store_sum();
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < PKT_LEN - 1; i++) s += pkt_bytes[i];
    return s;
  endfunction

  function automatic bit take_packet(output yaw_result_t r);
    logic [15:0] yaw;
    r = '0;
    if (pkt_bytes[1] != ANGLE_TYPE) return 1'b0;
    yaw = {pkt_bytes[7], pkt_bytes[6]};
    if (prev_yaw < QUARTER_TURN && yaw > THREE_QUARTER_TURN) begin
      turn_total -= 16'd1;
    end else if (prev_yaw > THREE_QUARTER_TURN && yaw < QUARTER_TURN) begin
      turn_total += 16'd1;
    end
    prev_yaw      = yaw;
    r.angle_count = {turn_total, yaw};
    r.yaw_raw     = yaw;
    r.turn_count  = turn_total;
    return 1'b1;
  endfunction

  function automatic bit framer_step(input logic [7:0] b, output yaw_result_t r);
    bit got;
    int hdr_at;
    r   = '0;
    got = 1'b0;
    if (pkt_fill < PKT_LEN) begin
      pkt_bytes[pkt_fill] = b;
      pkt_fill++;
    end
    if (pkt_fill < PKT_LEN) return 1'b0;
    if (locked) begin
      if (store_sum() == pkt_bytes[PKT_LEN-1]) begin
        pkt_fill = 0;
        return take_packet(r);
      end
      locked = 1'b0;
    end
    // first header byte wins
    hdr_at = PKT_LEN;
    for (int i = PKT_LEN - 1; i >= 0; i--) begin
      if (pkt_bytes[i] == HEADER_BYTE) hdr_at = i;
    end
    if (hdr_at == PKT_LEN) begin
      pkt_fill = 0;
    end else if (hdr_at > 0) begin
      for (int i = 0; i + hdr_at < PKT_LEN; i++) pkt_bytes[i] = pkt_bytes[i + hdr_at];
      pkt_fill = PKT_LEN - hdr_at;
    end else begin
      if (store_sum() == pkt_bytes[PKT_LEN-1]) begin
        got    = take_packet(r);
        locked = 1'b1;
      end
      pkt_fill = 0;
    end
    return got;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit has_known, input yaw_result_t known);
    yaw_result_t r;
    bit          got;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    got = framer_step(b, r);
    if (has_known) pending_angles.push_back(known);
    else if (got) pending_angles.push_back(r);
  endtask

  function automatic logic [15:0] pick_yaw();
    logic [15:0] edges [8];
    edges = '{16'd0, 16'd16383, 16'd16384, 16'd16385,
              16'd49151, 16'd49152, 16'd49153, 16'd65535};
    case ($urandom_range(3))
      0:       return edges[$urandom_range(7)];
      1:       return 16'($urandom_range(16383));
      2:       return 16'($urandom_range(65535, 49153));
      default: return 16'($urandom);
    endcase
  endfunction

  // keep < PKT_LEN sends a truncated packet
  task automatic send_packet(input logic [7:0] kind, input logic [15:0] yaw,
                             input bit good_sum, input int keep);
    logic [7:0] p [PKT_LEN];
    logic [7:0] s;
    p[0] = HEADER_BYTE;
    p[1] = kind;
    for (int i = 2; i < PKT_LEN - 1; i++) p[i] = 8'($urandom);
    p[6] = yaw[7:0];
    p[7] = yaw[15:8];
    s = 8'h00;
    for (int i = 0; i < PKT_LEN - 1; i++) s += p[i];
    p[PKT_LEN-1] = good_sum ? s : s ^ (8'h01 << $urandom_range(7));
    for (int i = 0; i < keep; i++) send_byte(p[i], 1'b0, '0);
  endtask

  task automatic note_mismatch(input string what, input yaw_result_t want,
                               input yaw_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s: expected angle %h yaw %h turns %h, got angle %h yaw %h turns %h",
               $realtime, what, want.angle_count, want.yaw_raw, want.turn_count,
               got.angle_count, got.yaw_raw, got.turn_count);
    end
  endtask

  // result side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_angle = out_tdata;
      if (pending_angles.size() == 0) begin
        note_mismatch("unexpected result", '0, seen_angle);
      end else begin
        due_angle = pending_angles.pop_front();
        if (seen_angle.angle_count !== due_angle.angle_count ||
            seen_angle.yaw_raw !== due_angle.yaw_raw ||
            seen_angle.turn_count !== due_angle.turn_count) begin
          note_mismatch("wrong result", due_angle, seen_angle);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [7:0] kind;
    int         roll;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIR_ROWS[i].data, DIR_ROWS[i].known, DIR_ROWS[i].result);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 80; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 80; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      while (bytes_sent < N_DIRECTED + (ph + 1) * RANDOM_BYTES / 4) begin
        roll = $urandom_range(99);
        if (roll < 60) begin
          send_packet(ANGLE_TYPE, pick_yaw(), 1'b1, PKT_LEN);
        end else if (roll < 70) begin
          do kind = 8'($urandom); while (kind == ANGLE_TYPE);
          send_packet(kind, pick_yaw(), 1'b1, PKT_LEN);
        end else if (roll < 80) begin
          send_packet(ANGLE_TYPE, pick_yaw(), 1'b0, PKT_LEN);
        end else if (roll < 88) begin
          send_packet(ANGLE_TYPE, pick_yaw(), 1'b1, $urandom_range(PKT_LEN - 1, 1));
        end else begin
          // line noise, with stray header bytes now and then
          repeat ($urandom_range(14, 1)) begin
            send_byte(($urandom_range(3) == 0) ? HEADER_BYTE : 8'($urandom), 1'b0, '0);
          end
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_angles.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
